[rtl/core/rkiq_pkg.sv]
// Shared types, constants and helpers for the rotary knob input qualifier.
package rkiq_pkg;

  localparam int AGE_BITS = 16;
  localparam int SUM_BITS = 8;
  localparam int SUM_MAX  = (2 ** (SUM_BITS - 1)) - 1;

  localparam int CLICK_LIMIT = 500;
  localparam int LONG_LIMIT  = 1000;
  localparam int REST_SEEN   = 250;

  localparam logic [7:0] RUN_CAP   = 8'd255;
  localparam logic [1:0] PAIR_REST = 2'b11;
  localparam logic [1:0] PAIR_LOW  = 2'b00;
  localparam logic [3:0] HIST_RST  = 4'hF;

  localparam logic [2:0] CFG_WIDTH = 3;

  typedef enum logic [2:0] {
    REG_REVERSE_DIR    = 3'd0,
    REG_LOCKOUT_MS     = 3'd1,
    REG_DEBOUNCE_MS    = 3'd2,
    REG_DETENT_MODE    = 3'd3,
    REG_STABLE_SAMPLES = 3'd4
  } reg_idx_t;

  typedef enum logic [1:0] {
    ROT_NONE = 2'd0,
    ROT_CW   = 2'd1,
    ROT_CCW  = 2'd2
  } rot_evt_t;

  typedef enum logic [1:0] {
    BTN_NONE  = 2'd0,
    BTN_CLICK = 2'd1,
    BTN_LONG  = 2'd2
  } btn_evt_t;

  localparam logic signed [1:0] MODE_BOTH = 2'sd1;

  typedef struct packed {
    logic              reverse_dir;
    logic [15:0]       lockout_ms;
    logic [15:0]       debounce_ms;
    logic signed [1:0] detent_mode;
    logic [7:0]        stable_samples;
  } cfg_t;

  typedef struct packed {
    logic              load;
    logic signed [1:0] value;
  } mode_load_t;

  function automatic logic [AGE_BITS-1:0] age_up(input logic [AGE_BITS-1:0] a);
    return (a == '1) ? a : a + 1'b1;
  endfunction

  // Quadrature transition table: index = {new pair, old pair}.
  function automatic logic signed [1:0] step_lut(input logic [3:0] idx);
    logic signed [1:0] v;
    v = 2'sd0;
    unique case (idx)
      4'd1:    v = -2'sd1;
      4'd4:    v = 2'sd1;
      4'd11:   v = 2'sd1;
      4'd14:   v = -2'sd1;
      default: v = 2'sd0;
    endcase
    return v;
  endfunction

endpackage

[rtl/core/rotary_knob_input_qualifier_top.sv]
// A request accepted at a clock edge shows its registered result on out_* right after that edge.
// Throughput: one request per clock; in_ready = !out_valid || out_ready, so the
//   single result register is refilled in the same cycle it is drained.
// Rate is set by the one-pass update of decoder and debounce state per request.
// Reset (rst_n low, synchronous): config back to defaults, all state to rest,
//   result register empty. cfg_ready is always high.
module rotary_knob_input_qualifier_top (
  input  logic                      clk,
  input  logic                      rst_n,
  // request channel
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [1:0]                in_contact_pair,
  input  logic                      in_switch_pressed,
  // result channel
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [1:0]                out_rotate_event,
  output logic [1:0]                out_button_event,
  output logic                      out_button_held,
  output logic [15:0]               out_held_time,
  output logic signed [1:0]         out_detent_state,
  // config write channel
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [rkiq_pkg::CFG_WIDTH-1:0] cfg_index,
  input  logic [15:0]               cfg_data
);
  import rkiq_pkg::*;

  cfg_t       cfg_r;
  mode_load_t mode_ld;
  logic       cfg_we;
  logic       tick;

  rot_evt_t          rot_nxt;
  logic signed [1:0] mode_nxt;
  btn_evt_t          btn_nxt;
  logic              down_nxt;
  logic [15:0]       held_nxt;

  logic              out_valid_r;
  logic [1:0]        rot_r, btn_r;
  logic              held_r;
  logic [15:0]       held_time_r;
  logic signed [1:0] mode_r;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;
  assign in_ready  = !out_valid_r || out_ready;
  assign tick      = in_valid && in_ready;

  // Writing a new detent mode also reloads the kept mode.
  assign mode_ld.load  = cfg_we && cfg_index == REG_DETENT_MODE &&
                         cfg_data[1:0] != cfg_r.detent_mode;
  assign mode_ld.value = cfg_data[1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.reverse_dir    <= 1'b0;
      cfg_r.lockout_ms     <= 16'd10;
      cfg_r.debounce_ms    <= 16'd20;
      cfg_r.detent_mode    <= -2'sd1;
      cfg_r.stable_samples <= 8'd2;
    end else if (cfg_we) begin
      priority case (cfg_index)
        REG_REVERSE_DIR:    cfg_r.reverse_dir    <= cfg_data[0];
        REG_LOCKOUT_MS:     cfg_r.lockout_ms     <= cfg_data;
        REG_DEBOUNCE_MS:    cfg_r.debounce_ms    <= cfg_data;
        REG_DETENT_MODE:    cfg_r.detent_mode    <= cfg_data[1:0];
        REG_STABLE_SAMPLES: cfg_r.stable_samples <= cfg_data[7:0];
        default:            ;
      endcase
    end
  end

  rkiq_quad u_quad (
    .clk          (clk),
    .rst_n        (rst_n),
    .tick         (tick),
    .contact_pair (in_contact_pair),
    .cfg          (cfg_r),
    .mode_ld      (mode_ld),
    .rot_nxt      (rot_nxt),
    .mode_nxt     (mode_nxt)
  );

  rkiq_switch u_switch (
    .clk            (clk),
    .rst_n          (rst_n),
    .tick           (tick),
    .switch_pressed (in_switch_pressed),
    .debounce_ms    (cfg_r.debounce_ms),
    .btn_nxt        (btn_nxt),
    .down_nxt       (down_nxt),
    .held_nxt       (held_nxt)
  );

  // result register: valid bit reset, payload loaded on each request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (tick) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (tick) begin
      rot_r       <= rot_nxt;
      btn_r       <= btn_nxt;
      held_r      <= down_nxt;
      held_time_r <= held_nxt;
      mode_r      <= mode_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_rotate_event = rot_r;
  assign out_button_event = btn_r;
  assign out_button_held  = held_r;
  assign out_held_time    = held_time_r;
  assign out_detent_state = mode_r;

endmodule

[rtl/core/rkiq_quad.sv]
// A/B glitch filter, transition decoder, detent and lockout logic.
module rkiq_quad (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     tick,
  input  logic [1:0]               contact_pair,
  input  rkiq_pkg::cfg_t           cfg,
  input  rkiq_pkg::mode_load_t     mode_ld,
  output rkiq_pkg::rot_evt_t       rot_nxt,
  output logic signed [1:0]        mode_nxt
);
  import rkiq_pkg::*;

  logic [1:0]                 shown_r, shown_nxt;
  logic [1:0]                 cand_r, cand_nxt;
  logic [7:0]                 run_r, run_nxt;
  logic [AGE_BITS-1:0]        pair_age_r, pair_age_nxt;
  logic [3:0]                 hist_r, hist_nxt;
  logic signed [SUM_BITS-1:0] sum_r, sum_nxt;
  logic signed [SUM_BITS:0]   sum_ext;
  logic [AGE_BITS-1:0]        since_r, since_nxt, since_inc;
  logic signed [1:0]          kept_r;
  logic                       at_detent;
  logic                       forward;

  always_comb begin
    shown_nxt    = shown_r;
    cand_nxt     = cand_r;
    run_nxt      = run_r;
    mode_nxt     = kept_r;
    rot_nxt      = ROT_NONE;
    sum_ext      = '0;
    forward      = 1'b0;
    since_inc    = age_up(since_r);
    since_nxt    = since_inc;

    // glitch filter
    if (contact_pair == shown_r) begin
      cand_nxt = contact_pair;
      run_nxt  = '0;
    end else begin
      if (contact_pair != cand_r) begin
        cand_nxt = contact_pair;
        run_nxt  = 8'd1;
      end else if (run_r < RUN_CAP) begin
        run_nxt = run_r + 8'd1;
      end
      if (run_nxt >= cfg.stable_samples) begin
        shown_nxt = contact_pair;
        run_nxt   = '0;
      end
    end
    pair_age_nxt = (shown_nxt != shown_r) ? '0 : age_up(pair_age_r);

    // auto promotion after a long rest at 00
    if (kept_r[1] && shown_nxt == PAIR_LOW &&
        32'(pair_age_nxt) >= 32'(REST_SEEN)) begin
      mode_nxt = MODE_BOTH;
    end

    if (32'(since_inc) < 32'(cfg.lockout_ms)) begin
      sum_nxt  = '0;
      hist_nxt = {shown_nxt, shown_nxt};
    end else begin
      hist_nxt = {shown_nxt, hist_r[3:2]};
      sum_ext  = (SUM_BITS+1)'(sum_r) + (SUM_BITS+1)'(step_lut(hist_nxt));
      if (sum_ext > (SUM_BITS+1)'(SUM_MAX)) begin
        sum_nxt = SUM_BITS'(SUM_MAX);
      end else if (sum_ext < -(SUM_BITS+1)'(SUM_MAX)) begin
        sum_nxt = -SUM_BITS'(SUM_MAX);
      end else begin
        sum_nxt = SUM_BITS'(sum_ext);
      end
    end

    at_detent = (shown_nxt == PAIR_REST) ||
                (mode_nxt == MODE_BOTH && shown_nxt == PAIR_LOW);
    if (sum_nxt != '0 && at_detent) begin
      forward   = (sum_nxt > 0) != cfg.reverse_dir;
      since_nxt = '0;
      sum_nxt   = '0;
      hist_nxt  = {shown_nxt, shown_nxt};
      rot_nxt   = forward ? ROT_CW : ROT_CCW;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shown_r    <= PAIR_REST;
      cand_r     <= PAIR_REST;
      run_r      <= '0;
      pair_age_r <= '0;
      hist_r     <= HIST_RST;
      sum_r      <= '0;
      since_r    <= '1;
      kept_r     <= -2'sd1;
    end else if (mode_ld.load) begin
      kept_r <= mode_ld.value;
    end else if (tick) begin
      shown_r    <= shown_nxt;
      cand_r     <= cand_nxt;
      run_r      <= run_nxt;
      pair_age_r <= pair_age_nxt;
      hist_r     <= hist_nxt;
      sum_r      <= sum_nxt;
      since_r    <= since_nxt;
      kept_r     <= mode_nxt;
    end
  end

endmodule

[rtl/core/rkiq_switch.sv]
// Switch debounce with click and long-press detection.
module rkiq_switch (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       tick,
  input  logic                       switch_pressed,
  input  logic [15:0]                debounce_ms,
  output rkiq_pkg::btn_evt_t         btn_nxt,
  output logic                       down_nxt,
  output logic [15:0]                held_nxt
);
  import rkiq_pkg::*;

  logic                sample_r, sample_nxt;
  logic [AGE_BITS-1:0] sample_age_r, sample_age_nxt;
  logic                down_r;
  logic [AGE_BITS-1:0] down_age_r, down_age_nxt;
  logic                long_r, long_nxt;

  always_comb begin
    sample_nxt     = sample_r;
    sample_age_nxt = age_up(sample_age_r);
    down_age_nxt   = age_up(down_age_r);
    down_nxt       = down_r;
    long_nxt       = long_r;
    btn_nxt        = BTN_NONE;

    if (switch_pressed != sample_r) begin
      sample_nxt     = switch_pressed;
      sample_age_nxt = '0;
    end
    if (switch_pressed != down_r && 32'(sample_age_nxt) >= 32'(debounce_ms)) begin
      if (switch_pressed) begin
        down_age_nxt = '0;
        long_nxt     = 1'b0;
      end else if (!long_r && 32'(down_age_nxt) < 32'(CLICK_LIMIT)) begin
        btn_nxt = BTN_CLICK;
      end
      down_nxt = switch_pressed;
    end
    if (down_nxt && !long_nxt && 32'(down_age_nxt) >= 32'(LONG_LIMIT)) begin
      long_nxt = 1'b1;
      btn_nxt  = BTN_LONG;
    end
    held_nxt = down_nxt ? 16'(down_age_nxt) : 16'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_r     <= 1'b0;
      sample_age_r <= '0;
      down_r       <= 1'b0;
      down_age_r   <= '0;
      long_r       <= 1'b0;
    end else if (tick) begin
      sample_r     <= sample_nxt;
      sample_age_r <= sample_age_nxt;
      down_r       <= down_nxt;
      down_age_r   <= down_age_nxt;
      long_r       <= long_nxt;
    end
  end

endmodule

[rtl/core/rkiq_checker.sv]
// Port-level assertions for the knob qualifier, bound to the top level.
module rkiq_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic [1:0]                in_contact_pair,
  input logic                      in_switch_pressed,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [1:0]                out_rotate_event,
  input logic [1:0]                out_button_event,
  input logic                      out_button_held,
  input logic [15:0]               out_held_time,
  input logic signed [1:0]         out_detent_state,
  input logic                      cfg_valid,
  input logic                      cfg_ready,
  input logic [rkiq_pkg::CFG_WIDTH-1:0] cfg_index,
  input logic [15:0]               cfg_data
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_rotate_event) &&
    $stable(out_button_event) && $stable(out_held_time))
    else $error("result changed while stalled");

  // one request in, one result out
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("accepted request produced no result");

  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty result register");

  a_held_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_button_held |-> out_held_time == 16'd0)
    else $error("held time nonzero while released");

  a_codes: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_rotate_event != 2'd3 && out_button_event != 2'd3)
    else $error("illegal event code");

endmodule

bind rotary_knob_input_qualifier_top rkiq_checker u_rkiq_checker (.*);

[tb/sv/rotary_knob_input_qualifier_checker.sv]
`timescale 1ns / 100ps
// Channel monitor with its own knob/switch predictor and report comparison.
module rotary_knob_input_qualifier_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  logic [1:0]                     in_contact_pair,
  input  logic                           in_switch_pressed,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  logic [1:0]                     out_rotate_event,
  input  logic [1:0]                     out_button_event,
  input  logic                           out_button_held,
  input  logic [15:0]                    out_held_time,
  input  logic signed [1:0]              out_detent_state,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [rkiq_pkg::CFG_WIDTH-1:0] cfg_index,
  input  logic [15:0]                    cfg_data,
  output int                             mismatch_count,
  output int                             pending
);
  import rkiq_pkg::*;

  typedef struct packed {
    rot_evt_t          rot;
    btn_evt_t          btn;
    logic              held;
    logic [15:0]       held_time;
    logic signed [1:0] detent;
  } knob_report_t;

  // index = {new pair, old pair}
  localparam int TURN_WEIGHT [16] = '{0, -1, 0, 0, 1, 0, 0, 0, 0, 0, 0, 1, 0, 0, -1, 0};

  knob_report_t expected_reports [$];

  // register copy
  logic        cfg_reverse;
  logic [15:0] cfg_lockout;
  logic [15:0] cfg_debounce;
  logic [1:0]  cfg_mode;
  logic [7:0]  cfg_stable;

  // decoder and debounce state
  logic [1:0]  shown_pair, cand_pair;
  logic [7:0]  cand_run;
  logic [15:0] pair_age, since_step;
  logic [3:0]  pair_hist;
  int          dir_sum, kept_mode;
  logic        sw_sample, sw_down, long_sent;
  logic [15:0] sw_age, down_age;

  initial begin
    mismatch_count = 0;
    pending        = 0;
  end

  function automatic logic [15:0] sat_tick(input logic [15:0] a);
    return (a == 16'hFFFF) ? a : a + 16'd1;
  endfunction

  task automatic clear_model();
    cfg_reverse  = 1'b0;
    cfg_lockout  = 16'd10;
    cfg_debounce = 16'd20;
    cfg_mode     = 2'b11;
    cfg_stable   = 8'd2;
    shown_pair   = PAIR_REST;
    cand_pair    = PAIR_REST;
    cand_run     = '0;
    pair_age     = '0;
    pair_hist    = HIST_RST;
    dir_sum      = 0;
    since_step   = 16'hFFFF;
    kept_mode    = $signed(cfg_mode);
    sw_sample    = 1'b0;
    sw_age       = '0;
    sw_down      = 1'b0;
    down_age     = '0;
    long_sent    = 1'b0;
  endtask

  task automatic write_register(input logic [2:0] idx, input logic [15:0] data);
    case (idx)
      REG_REVERSE_DIR:    cfg_reverse  = data[0];
      REG_LOCKOUT_MS:     cfg_lockout  = data;
      REG_DEBOUNCE_MS:    cfg_debounce = data;
      REG_DETENT_MODE: begin
        // only a changed value reloads the kept mode
        if (data[1:0] != cfg_mode) begin
          cfg_mode  = data[1:0];
          kept_mode = $signed(data[1:0]);
        end
      end
      REG_STABLE_SAMPLES: cfg_stable = data[7:0];
      default: ;
    endcase
  endtask

  task automatic decode_tick(input logic [1:0] raw, input logic sw, output knob_report_t rep);
    logic [1:0] prev_shown;
    logic       at_detent, forward;
    prev_shown = shown_pair;
    rep.rot    = ROT_NONE;
    rep.btn    = BTN_NONE;

    pair_age   = sat_tick(pair_age);
    since_step = sat_tick(since_step);
    sw_age     = sat_tick(sw_age);
    down_age   = sat_tick(down_age);

    // glitch filter
    if (raw == shown_pair) begin
      cand_pair = raw;
      cand_run  = '0;
    end else begin
      if (raw != cand_pair) begin
        cand_pair = raw;
        cand_run  = 8'd1;
      end else if (cand_run < RUN_CAP) begin
        cand_run = cand_run + 8'd1;
      end
      if (cand_run >= cfg_stable) begin
        shown_pair = raw;
        cand_run   = '0;
      end
    end
    if (shown_pair != prev_shown) pair_age = '0;

    if (kept_mode < 0 && shown_pair == PAIR_LOW && pair_age >= REST_SEEN) kept_mode = 1;

    if (since_step < cfg_lockout) begin
      dir_sum   = 0;
      pair_hist = {shown_pair, shown_pair};
    end else begin
      pair_hist = {shown_pair, pair_hist[3:2]};
      dir_sum   = dir_sum + TURN_WEIGHT[pair_hist];
      if (dir_sum > SUM_MAX) dir_sum = SUM_MAX;
      if (dir_sum < -SUM_MAX) dir_sum = -SUM_MAX;
    end

    at_detent = (shown_pair == PAIR_REST) || (kept_mode == 1 && shown_pair == PAIR_LOW);
    if (dir_sum != 0 && at_detent) begin
      forward    = (dir_sum > 0) != cfg_reverse;
      since_step = '0;
      dir_sum    = 0;
      pair_hist  = {shown_pair, shown_pair};
      rep.rot    = forward ? ROT_CW : ROT_CCW;
    end

    // switch debounce
    if (sw != sw_sample) begin
      sw_sample = sw;
      sw_age    = '0;
    end
    if (sw != sw_down && sw_age >= cfg_debounce) begin
      if (sw) begin
        down_age  = '0;
        long_sent = 1'b0;
      end else if (!long_sent && down_age < CLICK_LIMIT) begin
        rep.btn = BTN_CLICK;
      end
      sw_down = sw;
    end
    if (sw_down && !long_sent && down_age >= LONG_LIMIT) begin
      long_sent = 1'b1;
      rep.btn   = BTN_LONG;
    end

    rep.held      = sw_down;
    rep.held_time = sw_down ? down_age : 16'd0;
    rep.detent    = kept_mode[1:0];
  endtask

  task automatic check_field(input string label, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, label, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin : monitor
    knob_report_t want, next_rep;
    if (!rst_n) begin
      clear_model();
      expected_reports.delete();
    end else begin
      if (cfg_valid && cfg_ready) write_register(cfg_index, cfg_data);
      if (out_valid && out_ready) begin
        if (expected_reports.size() == 0) begin
          $display("%0t: report with no request outstanding", $time);
          mismatch_count++;
        end else begin
          want = expected_reports.pop_front();
          check_field("rotate_event", int'(want.rot), int'(out_rotate_event));
          check_field("button_event", int'(want.btn), int'(out_button_event));
          check_field("button_held", int'(want.held), int'(out_button_held));
          check_field("held_time", int'(want.held_time), int'(out_held_time));
          check_field("detent_state", int'(want.detent), int'(out_detent_state));
        end
      end
      if (in_valid && in_ready) begin
        decode_tick(in_contact_pair, in_switch_pressed, next_rep);
        expected_reports.push_back(next_rep);
      end
    end
    pending = expected_reports.size();
  end

endmodule

[tb/sv/rotary_knob_input_qualifier_top_test.sv]
`timescale 1ns / 100ps
// Top of the knob qualifier testbench: clock, reset, stimulus phases and verdict.
module rotary_knob_input_qualifier_top_test;
  import rkiq_pkg::*;

  // quadrature pair codes besides the two package ones (bit1 B, bit0 A)
  localparam logic [1:0] PAIR_B_OPEN = 2'b10;
  localparam logic [1:0] PAIR_A_OPEN = 2'b01;

  // detent_mode register codes
  localparam logic [1:0] MODE_AUTO      = 2'b11;
  localparam logic [1:0] MODE_ONLY_REST = 2'b00;
  localparam logic [1:0] MODE_BOTH_CODE = MODE_BOTH;
  localparam logic [1:0] MODE_NEG_TWO   = 2'b10;

  // quiet cycles allowed before the run is declared hung
  localparam int STALL_LIMIT = 2000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_contact_pair = PAIR_REST;
  logic        in_switch_pressed = 1'b0;

  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [1:0]        out_rotate_event;
  logic [1:0]        out_button_event;
  logic              out_button_held;
  logic [15:0]       out_held_time;
  logic signed [1:0] out_detent_state;

  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [CFG_WIDTH-1:0]     cfg_index = '0;
  logic [15:0]              cfg_data = '0;

  int mismatch_count;
  int pending;

  // when set, neither side inserts idle cycles
  logic calm = 1'b0;

  // mirror of the settings, used only to shape the stimulus
  int lockout_cur  = 10;
  int debounce_cur = 20;
  int stable_cur   = 2;

  // planned per-tick values; knob motion and switch activity are planned apart
  logic [1:0] pair_plan [$];
  logic       sw_plan [$];

  rotary_knob_input_qualifier_top u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_contact_pair   (in_contact_pair),
    .in_switch_pressed (in_switch_pressed),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_rotate_event  (out_rotate_event),
    .out_button_event  (out_button_event),
    .out_button_held   (out_button_held),
    .out_held_time     (out_held_time),
    .out_detent_state  (out_detent_state),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  rotary_knob_input_qualifier_checker u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_contact_pair   (in_contact_pair),
    .in_switch_pressed (in_switch_pressed),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_rotate_event  (out_rotate_event),
    .out_button_event  (out_button_event),
    .out_button_held   (out_button_held),
    .out_held_time     (out_held_time),
    .out_detent_state  (out_detent_state),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .mismatch_count    (mismatch_count),
    .pending           (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Result side backpressure: about 36% stall, none while calm.
  always @(negedge clk) begin
    out_ready <= calm || ($urandom_range(0, 99) >= 36);
  end

  // Watchdog: any handshake restarts the count.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("== FAIL ==");
    $finish;
  end

  // One request: optional idle gap, then valid held until accepted.
  // Valid stays up into the next call, so back-to-back requests need no gap.
  task automatic send_tick(input logic [1:0] pair, input logic sw);
    @(negedge clk);
    while (!calm && $urandom_range(0, 99) < 36) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid          <= 1'b1;
    in_contact_pair   <= pair;
    in_switch_pressed <= sw;
    do begin
      @(posedge clk);
    end while (!in_ready);
  endtask

  // Drop valid and wait for every outstanding report.
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [15:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do begin
      @(posedge clk);
    end while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_config(input logic rev, input logic [15:0] lock, input logic [15:0] deb,
                            input logic [1:0] mode, input logic [7:0] stable);
    settle();
    write_reg(REG_REVERSE_DIR, {15'd0, rev});
    write_reg(REG_LOCKOUT_MS, lock);
    write_reg(REG_DEBOUNCE_MS, deb);
    write_reg(REG_DETENT_MODE, {14'd0, mode});
    write_reg(REG_STABLE_SAMPLES, {8'd0, stable});
    lockout_cur  = int'(lock);
    debounce_cur = int'(deb);
    stable_cur   = int'(stable);
  endtask

  task automatic hold_ticks(input logic [1:0] pair, input logic sw, input int n);
    repeat (n) begin
      pair_plan.push_back(pair);
      sw_plan.push_back(sw);
    end
  endtask

  // Knob plans: mostly clean detent-to-detent turns with random holds and
  // the odd glitch, otherwise noise or long rests (a 00 rest can promote auto mode).
  task automatic plan_motion();
    int         kind, hold, pad, idx;
    logic       cw;
    logic [1:0] ring [4];
    logic [1:0] pair;
    ring[0] = PAIR_B_OPEN;
    ring[1] = PAIR_LOW;
    ring[2] = PAIR_A_OPEN;
    ring[3] = PAIR_REST;
    kind = $urandom_range(0, 99);
    if (kind < 70) begin
      cw = 1'($urandom_range(0, 1));
      repeat ($urandom_range(1, 3)) begin
        for (int k = 0; k < 4; k++) begin
          // clockwise walks 10,00,01,11; the other way 01,00,10,11
          idx = (cw || k == 3) ? k : 2 - k;
          if ($urandom_range(0, 99) < 15) pair_plan.push_back(2'($urandom_range(0, 3)));
          hold = ((stable_cur == 0) ? 1 : stable_cur) + $urandom_range(0, 2);
          repeat (hold) pair_plan.push_back(ring[idx]);
        end
        // usually sit out the lockout, sometimes turn straight into it
        pad = ($urandom_range(0, 4) == 0) ? 0 :
              ((lockout_cur < 20) ? lockout_cur : 20) + $urandom_range(0, 3);
        repeat (pad) pair_plan.push_back(PAIR_REST);
      end
    end else if (kind < 85) begin
      repeat ($urandom_range(1, 8)) begin
        pair = 2'($urandom_range(0, 3));
        repeat ($urandom_range(1, 3)) pair_plan.push_back(pair);
      end
    end else begin
      pair = $urandom_range(0, 1) ? PAIR_REST : PAIR_LOW;
      repeat ($urandom_range(5, 40)) pair_plan.push_back(pair);
    end
  endtask

  task automatic add_chatter();
    repeat ($urandom_range(0, 3)) begin
      repeat ($urandom_range(1, 2)) sw_plan.push_back(1'b1);
      repeat ($urandom_range(1, 2)) sw_plan.push_back(1'b0);
    end
  endtask

  // Switch plans: bounce-only bursts, clicks, presses around the click
  // limit, and occasional long presses.
  task automatic plan_button();
    int   kind, deb, len;
    logic lvl;
    deb  = (debounce_cur < 60) ? debounce_cur : 60;
    kind = $urandom_range(0, 99);
    if (kind < 20) begin
      repeat ($urandom_range(1, 6)) begin
        lvl = 1'($urandom_range(0, 1));
        repeat ($urandom_range(1, 3)) sw_plan.push_back(lvl);
      end
    end else begin
      if (kind < 30)      len = LONG_LIMIT + deb + $urandom_range(0, 80);
      else if (kind < 75) len = deb + $urandom_range(1, 480);
      else                len = deb + $urandom_range(450, 700);
      add_chatter();
      repeat (len) sw_plan.push_back(1'b1);
      add_chatter();
    end
    repeat (deb + $urandom_range(1, 40)) sw_plan.push_back(1'b0);
  endtask

  // Random phase: the two plans refill on their own as they run dry.
  task automatic run_ticks(input int n, input int calm_n);
    for (int i = 0; i < n; i++) begin
      if (pair_plan.size() == 0) plan_motion();
      if (sw_plan.size() == 0) plan_button();
      calm = (i < calm_n);
      send_tick(pair_plan.pop_front(), sw_plan.pop_front());
    end
    calm = 1'b0;
    pair_plan.delete();
    sw_plan.delete();
  endtask

  // Random knob motion with the raw switch held down throughout.
  task automatic run_knob_held(input int n, input int calm_n);
    for (int i = 0; i < n; i++) begin
      if (pair_plan.size() == 0) plan_motion();
      calm = (i < calm_n);
      send_tick(pair_plan.pop_front(), 1'b1);
    end
    calm = 1'b0;
    pair_plan.delete();
  endtask

  task automatic drain_plan();
    while (pair_plan.size() != 0) send_tick(pair_plan.pop_front(), sw_plan.pop_front());
  endtask

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed, reset settings: one-tick glitch on both inputs is filtered,
    // then a clockwise detent, a wait past lockout, and a counterclockwise
    // detent with raw switch held too briefly to pass the debounce.
    hold_ticks(PAIR_LOW, 1'b1, 1);
    hold_ticks(PAIR_REST, 1'b0, 1);
    hold_ticks(PAIR_B_OPEN, 1'b0, 2);
    hold_ticks(PAIR_LOW, 1'b0, 2);
    hold_ticks(PAIR_A_OPEN, 1'b0, 2);
    hold_ticks(PAIR_REST, 1'b0, 10);
    hold_ticks(PAIR_A_OPEN, 1'b1, 2);
    hold_ticks(PAIR_LOW, 1'b1, 2);
    hold_ticks(PAIR_B_OPEN, 1'b1, 2);
    hold_ticks(PAIR_REST, 1'b1, 2);
    drain_plan();
    run_ticks(20, 0);

    // switch released and knob at rest before the long press
    hold_ticks(PAIR_REST, 1'b0, 25);
    drain_plan();

    // Long press held across several settings: 00 rests past the promotion
    // threshold in auto mode, then in mode code 10, then random turns.
    set_config(1'b0, 16'd0, 16'd5, MODE_AUTO, 8'd1);
    hold_ticks(PAIR_LOW, 1'b1, 300);
    drain_plan();

    // Rewriting the same mode value must not undo the promotion.
    settle();
    write_reg(REG_DETENT_MODE, {14'd0, MODE_AUTO});
    hold_ticks(PAIR_REST, 1'b1, 10);
    drain_plan();

    // Mode code 10 behaves as negative: a long 00 rest promotes it.
    settle();
    write_reg(REG_DETENT_MODE, {14'd0, MODE_NEG_TWO});
    hold_ticks(PAIR_LOW, 1'b1, 260);
    drain_plan();

    // Reversed, no lockout, both detents, stable count zero, switch still
    // held into the long press. Starts with a stretch where neither side stalls.
    set_config(1'b1, 16'd0, 16'd5, MODE_BOTH_CODE, 8'd0);
    run_knob_held(450, 200);

    // release after the long press gives no click
    hold_ticks(PAIR_REST, 1'b0, 10);
    drain_plan();

    // Every counter register at its top value, only the 11 detent.
    set_config(1'b0, 16'hFFFF, 16'hFFFF, MODE_ONLY_REST, 8'd255);
    run_ticks(30, 0);

    // Back near defaults; auto mode reloaded from a different value.
    set_config(1'b0, 16'd1, 16'd20, MODE_AUTO, 8'd2);
    run_ticks(30, 0);

    settle();
    repeat (3) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
